/* hw/rtl/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and calendar tables
// Controller states, command/status structs, Gregorian month tables.
// ----------------------------------------------------------------------------
`default_nettype none
package ptc_pkg;

	localparam int BCD_DIGITS = 13;
	localparam int STAMP_IN_W = 40;
	localparam int STAMP_OUT_W = 37;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_BCD   = 9'b000000010,
		ST_CHECK = 9'b000000100,
		ST_DIV   = 9'b000001000,
		ST_ADDQ  = 9'b000010000,
		ST_YEAR  = 9'b000100000,
		ST_PK1   = 9'b001000000,
		ST_PK2   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic load;
		logic bcd;
		logic check;
		logic div;
		logic addq;
		logic year;
		logic pk1;
		logic pk2;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic act;
		logic year_done;
	} status_t;

	function automatic logic [4:0] month_len(input logic lp, input logic [3:0] mo);
		logic [4:0] r;
		case (mo)
			4'd2:                      r = lp ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

	// days before the first of month mo
	function automatic logic [8:0] cum_days(input logic lp, input logic [3:0] mo);
		logic [8:0] r;
		case (mo)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		if (lp && mo > 4'd2) begin
			r = r + 9'd1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/ptc_ctrl.sv */
// ----------------------------------------------------------------------------
// ptc_ctrl: sequencing controller
// Steps one transaction through digit split, check, divide and year carry (hour additions only), pack.
// ----------------------------------------------------------------------------
`default_nettype none
module ptc_ctrl #(
	parameter int HOUR_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	output logic              done,
	input  ptc_pkg::status_t  sts,
	output ptc_pkg::cmd_t     cmd
);
	import ptc_pkg::*;

	localparam int BCD_STEPS = STAMP_IN_W / 2;
	// one byte of the hour total per divide step
	localparam int DIV_STEPS = (HOUR_BITS + 8) / 8;
	localparam int MAX_STEPS = (DIV_STEPS > BCD_STEPS) ? DIV_STEPS : BCD_STEPS;
	localparam int CNT_W = $clog2(MAX_STEPS + 1);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_BCD;
				end
			end
			ST_BCD: begin
				cmd.bcd = 1'b1;
				if (cnt_q == CNT_W'(BCD_STEPS - 1)) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!sts.act) begin
					state_d = ST_PK1;
				end else begin
					cmd.div = 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_ADDQ;
				end
			end
			ST_ADDQ: begin
				cmd.addq = 1'b1;
				state_d = ST_YEAR;
			end
			ST_YEAR: begin
				cmd.year = 1'b1;
				if (sts.year_done) state_d = ST_PK1;
			end
			ST_PK1: begin
				cmd.pk1 = 1'b1;
				state_d = ST_PK2;
			end
			ST_PK2: begin
				cmd.pk2 = 1'b1;
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n) cmd.fin |=> done)
		else $error("result not strobed after final pack");

endmodule
`default_nettype wire

/* hw/rtl/ptc_dp.sv */
// ----------------------------------------------------------------------------
// ptc_dp: calendar datapath
// Double-dabble digit split, field check, bytewise /24, year carry, packing.
// ----------------------------------------------------------------------------
`default_nettype none
module ptc_dp #(
	parameter int HOUR_BITS = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  ptc_pkg::cmd_t                      cmd,
	output ptc_pkg::status_t                   sts,
	input  wire                                action,
	input  wire [ptc_pkg::STAMP_IN_W-1:0]      stamp_in,
	input  wire [HOUR_BITS-1:0]                hour_offset,
	output logic                               valid_res,
	output logic [ptc_pkg::STAMP_OUT_W-1:0]    stamp_out
);
	import ptc_pkg::*;

	localparam int DSTEPS = (HOUR_BITS + 8) / 8;
	localparam int TB = 8 * DSTEPS;
	localparam int BW = 4 * BCD_DIGITS;
	localparam int SW = TB + 24;

	logic            act_q;
	logic [STAMP_IN_W-1:0] sh_q;
	logic [BW-1:0]   bcd_q;
	logic [HOUR_BITS-1:0] hrs_q;
	logic            ok_q;
	logic [13:0]     y_q;
	logic [6:0]      m100_q;
	logic [8:0]      m400_q;
	logic [22:0]     ddd_q;
	logic [4:0]      h_q;
	logic [5:0]      min_q;
	logic [TB-1:0]   tot_q;
	logic [TB-1:0]   quot_q;
	logic [4:0]      rem_q;
	logic [36:0]     acc_q;

	// one double-dabble bit: add 3 to digits >= 5, then shift
	function automatic logic [BW+STAMP_IN_W-1:0] dd_step(input logic [BW+STAMP_IN_W-1:0] x);
		logic [BW+STAMP_IN_W-1:0] t;
		t = x;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (t[STAMP_IN_W+4*i +: 4] >= 4'd5)
				t[STAMP_IN_W+4*i +: 4] = t[STAMP_IN_W+4*i +: 4] + 4'd3;
		end
		return {t[BW+STAMP_IN_W-2:0], 1'b0};
	endfunction

	logic [BW+STAMP_IN_W-1:0] dd1, dd2;
	assign dd1 = dd_step({bcd_q, sh_q});
	assign dd2 = dd_step(dd1);

	function automatic logic [3:0] dg(input logic [BW-1:0] b, input int i);
		return b[4*i +: 4];
	endfunction

	// field decode, layout chosen by action
	logic [3:0]  yd3, yd2, yd1, yd0;
	logic        hi_zero;
	logic [13:0] ybin;
	logic [6:0]  cen, mod100, hh, mi, dd, mo;
	logic [8:0]  mod400;
	logic [9:0]  d3;
	logic        lp, in_ok;
	logic [8:0]  ddd_chk;

	always_comb begin
		if (act_q) begin
			{yd3, yd2, yd1, yd0} = {dg(bcd_q, 10), dg(bcd_q, 9), dg(bcd_q, 8), dg(bcd_q, 7)};
			hi_zero = (dg(bcd_q, 12) == 4'd0) && (dg(bcd_q, 11) == 4'd0);
		end else begin
			{yd3, yd2, yd1, yd0} = {dg(bcd_q, 11), dg(bcd_q, 10), dg(bcd_q, 9), dg(bcd_q, 8)};
			hi_zero = (dg(bcd_q, 12) == 4'd0);
		end
		ybin = 14'(yd3 * 10'd1000) + 14'(yd2 * 7'd100) + 14'(yd1 * 4'd10) + 14'(yd0);
		cen = 7'(yd3 * 4'd10) + 7'(yd2);
		mod100 = 7'(yd1 * 4'd10) + 7'(yd0);
		mod400 = 9'(cen[1:0] * 7'd100) + 9'(mod100);
		lp = (ybin[1:0] == 2'd0) && (mod100 != 7'd0 || mod400 == 9'd0);
		mi = 7'(dg(bcd_q, 1) * 4'd10) + 7'(dg(bcd_q, 0));
		hh = 7'(dg(bcd_q, 3) * 4'd10) + 7'(dg(bcd_q, 2));
		dd = 7'(dg(bcd_q, 5) * 4'd10) + 7'(dg(bcd_q, 4));
		mo = 7'(dg(bcd_q, 7) * 4'd10) + 7'(dg(bcd_q, 6));
		d3 = 10'(dg(bcd_q, 6) * 7'd100) + 10'(dd);
		in_ok = hi_zero && ybin >= 14'd1900 && hh <= 7'd23 && mi <= 7'd59;
		if (act_q) begin
			in_ok = in_ok && d3 >= 10'd1 && d3 <= (lp ? 10'd366 : 10'd365);
			ddd_chk = d3[8:0];
		end else begin
			in_ok = in_ok && mo >= 7'd1 && mo <= 7'd12 && dd >= 7'd1
				&& dd <= 7'(month_len(lp, mo[3:0]));
			ddd_chk = cum_days(lp, mo[3:0]) + 9'(dd);
		end
	end

	// division by 24, one byte per step: n/24 = (n/8)/3, and
	// (k * 683) >> 11 equals k/3 for k below 2048
	logic [12:0] dnum;
	logic [9:0]  dn3;
	logic [19:0] dprod;
	logic [7:0]  qbyte;
	logic [12:0] qx24;
	assign dnum = {rem_q, tot_q[TB-1 -: 8]};
	assign dn3 = dnum[12:3];
	assign dprod = 20'(dn3) * 20'd683;
	assign qbyte = 8'(dprod >> 11);
	assign qx24 = 13'({qbyte, 4'b0000}) + 13'({qbyte, 3'b000});

	logic [SW-1:0] dsum;
	assign dsum = SW'(ddd_q) + SW'(quot_q);

	logic        ylp;
	logic [8:0]  ylen;
	assign ylp = (y_q[1:0] == 2'd0) && (m100_q != 7'd0 || m400_q == 9'd0);
	assign ylen = ylp ? 9'd366 : 9'd365;
	assign sts.act = act_q;
	assign sts.year_done = !ok_q || (ddd_q <= 23'(ylen));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_res <= 1'b0;
			ok_q <= 1'b0;
		end else begin
			if (cmd.check) ok_q <= in_ok;
			if (cmd.addq && dsum[SW-1:23] != '0) ok_q <= 1'b0;
			if (cmd.year && !sts.year_done && y_q == 14'd9999) ok_q <= 1'b0;
			if (cmd.fin) valid_res <= ok_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			sh_q <= stamp_in;
			bcd_q <= '0;
			hrs_q <= hour_offset;
		end
		if (cmd.bcd) begin
			{bcd_q, sh_q} <= dd2;
		end
		if (cmd.check) begin
			y_q <= ybin;
			m100_q <= mod100;
			m400_q <= mod400;
			ddd_q <= 23'(ddd_chk);
			h_q <= hh[4:0];
			min_q <= mi[5:0];
			tot_q <= TB'(hh[4:0]) + TB'(hrs_q);
			quot_q <= '0;
			rem_q <= '0;
		end
		if (cmd.div) begin
			rem_q <= 5'(dnum - qx24);
			quot_q <= (quot_q << 8) | TB'(qbyte);
			tot_q <= tot_q << 8;
		end
		if (cmd.addq) begin
			ddd_q <= dsum[22:0];
			h_q <= rem_q;
		end
		if (cmd.year && !sts.year_done) begin
			ddd_q <= ddd_q - 23'(ylen);
			y_q <= y_q + 14'd1;
			m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
			m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
		end
		if (cmd.pk1) begin
			acc_q <= 37'(y_q * 24'd10000000);
		end
		if (cmd.pk2) begin
			acc_q <= acc_q + 37'(ddd_q[8:0] * 14'd10000);
		end
		if (cmd.fin) begin
			stamp_out <= ok_q ? acc_q + 37'(ddd_q[8:0] * 14'd10000)
				+ 37'(h_q * 7'd100) + 37'(min_q) : '0;
		end
	end

	a_zero_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (valid_res || stamp_out == '0))
		else $error("invalid result carries nonzero stamp");
	a_year_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.year && ok_q) |-> (y_q <= 14'd9999))
		else $error("year past range while still valid");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div |=> (rem_q < 5'd24))
		else $error("divide remainder out of range");

endmodule
`default_nettype wire

/* hw/rtl/packed_timestamp_calendar_unit.sv */
// ----------------------------------------------------------------------------
// packed_timestamp_calendar_unit: decimal-packed calendar check and convert
// Validates yyyymmddhhmm / yyyydddhhmm stamps, converts to day of year and
// adds hour offsets with day and year carry.
// ----------------------------------------------------------------------------
//  channel | ports                               | handshake
//  input   | action, stamp_in, hour_offset       | start & !busy
//  result  | valid_res, stamp_out                | done, one cycle
//
//  Action 0: 20 digit-split steps, field check, then packing and the done strobe.
//  Action 1 adds D = (HOUR_BITS + 8) / 8 byte steps of the /24 (3 at the
//  default) and carries one year per cycle until the day fits the year.
//  busy stays high until the done cycle ends; the next transaction may be
//  accepted the cycle after done. Reset is asynchronous and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none
module packed_timestamp_calendar_unit #(
	parameter int HOUR_BITS = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire                                action,
	input  wire [ptc_pkg::STAMP_IN_W-1:0]      stamp_in,
	input  wire [HOUR_BITS-1:0]                hour_offset,
	output logic                               done,
	output logic                               valid_res,
	output logic [ptc_pkg::STAMP_OUT_W-1:0]    stamp_out
);
	import ptc_pkg::*;

	cmd_t    cmd;
	status_t sts;

	ptc_ctrl #(.HOUR_BITS(HOUR_BITS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	ptc_dp #(.HOUR_BITS(HOUR_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.stamp_in    (stamp_in),
		.hour_offset (hour_offset),
		.valid_res   (valid_res),
		.stamp_out   (stamp_out)
	);

endmodule
`default_nettype wire

/* sim/tb_packed_timestamp_calendar_unit.sv */
// ----------------------------------------------------------------------------
// tb_packed_timestamp_calendar_unit: self-checking bench for the calendar unit
// Drives month-day conversions and hour additions, directed corner stamps
// first and random ones after, and compares every result against a
// behavioral calendar predictor through a scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_packed_timestamp_calendar_unit;

	localparam int HOUR_BITS = 16;
	localparam int IN_W = ptc_pkg::STAMP_IN_W;
	localparam int OUT_W = ptc_pkg::STAMP_OUT_W;
	localparam int N_RANDOM = 1230;
	localparam int IDLE_LIMIT = 5000;

	localparam logic ACT_CONVERT = 1'b0;
	localparam logic ACT_ADD_HOURS = 1'b1;

	typedef struct {
		logic             ok;
		logic [OUT_W-1:0] stamp;
	} cal_result_t;

	// calendar predictor
	function automatic bit is_leap(longint unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic longint unsigned days_in_month(bit lp, longint unsigned mo);
		case (mo)
			2: return lp ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic cal_result_t predict_calendar(logic act, logic [IN_W-1:0] s_in,
			logic [HOUR_BITS-1:0] hrs);
		longint unsigned s, y, mo, d, h, m, doy, total, ylen;
		cal_result_t r;
		bit lp;
		s = s_in;
		r.ok = 1'b0;
		r.stamp = '0;
		h = s / 100 % 100;
		m = s % 100;
		if (h > 23 || m > 59) return r;
		if (act == ACT_CONVERT) begin
			y = s / 100000000;
			mo = s / 1000000 % 100;
			d = s / 10000 % 100;
			if (y < 1900 || y > 9999 || mo < 1 || mo > 12) return r;
			lp = is_leap(y);
			if (d < 1 || d > days_in_month(lp, mo)) return r;
			doy = d;
			for (longint unsigned k = 1; k < mo; k++) doy += days_in_month(lp, k);
		end else begin
			y = s / 10000000;
			doy = s / 10000 % 1000;
			if (y < 1900 || y > 9999) return r;
			if (doy < 1 || doy > 365 + is_leap(y)) return r;
			total = h + hrs;
			h = total % 24;
			doy += total / 24;
			ylen = 365 + is_leap(y);
			while (doy > ylen) begin
				doy -= ylen;
				y++;
				if (y > 9999) return r;
				ylen = 365 + is_leap(y);
			end
		end
		r.ok = 1'b1;
		r.stamp = OUT_W'(((y * 1000 + doy) * 100 + h) * 100 + m);
		return r;
	endfunction

	class calendar_scoreboard;
		cal_result_t pending[$];
		int          mismatches;
		int          unexpected;

		function void note_transaction(logic act, logic [IN_W-1:0] s,
				logic [HOUR_BITS-1:0] hrs);
			pending.push_back(predict_calendar(act, s, hrs));
		endfunction

		function void check_result(logic ok, logic [OUT_W-1:0] st);
			cal_result_t e;
			if (pending.size() == 0) begin
				unexpected++;
				$display("result with nothing pending: valid_res=%0b stamp_out=%0d", ok, st);
				return;
			end
			e = pending.pop_front();
			if (ok !== e.ok || st !== e.stamp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: valid_res exp %0b got %0b, stamp_out exp %0d got %0d",
						e.ok, ok, e.stamp, st);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 action = 1'b0;
	logic [IN_W-1:0]      stamp_in = '0;
	logic [HOUR_BITS-1:0] hour_offset = '0;
	logic                 busy, done, valid_res;
	logic [OUT_W-1:0]     stamp_out;

	calendar_scoreboard sb = new();
	int idle_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	packed_timestamp_calendar_unit #(.HOUR_BITS(HOUR_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.stamp_in(stamp_in), .hour_offset(hour_offset), .done(done),
		.valid_res(valid_res), .stamp_out(stamp_out)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(valid_res, stamp_out);
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// one transaction; start is held until accepted, lowered only by the caller
	task automatic send(logic act, logic [IN_W-1:0] s, logic [HOUR_BITS-1:0] hrs);
		start <= 1'b1;
		action <= act;
		stamp_in <= s;
		hour_offset <= hrs;
		do @(posedge clk); while (busy);
		sb.note_transaction(act, s, hrs);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			start <= 1'b0;
			action <= 1'($urandom);
			stamp_in <= IN_W'({$urandom, $urandom});
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [IN_W-1:0] md_stamp(int y, int mo, int d, int h, int m);
		return IN_W'((((longint'(y) * 100 + mo) * 100 + d) * 100 + h) * 100 + m);
	endfunction

	function automatic logic [IN_W-1:0] doy_stamp(int y, int doy, int h, int m);
		return IN_W'(((longint'(y) * 1000 + doy) * 100 + h) * 100 + m);
	endfunction

	function automatic int rand_year();
		case ($urandom_range(0, 5))
			0: return 1900 + $urandom_range(0, 3);
			1: return 9996 + $urandom_range(0, 3);
			2: return 400 * $urandom_range(5, 24);
			default: return $urandom_range(1900, 9999);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] rand_stamp(logic act);
		int y, mo, d, h, m;
		bit lp;
		y = rand_year();
		lp = is_leap(y);
		h = ($urandom_range(0, 15) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23);
		m = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
		case ($urandom_range(0, 19))
			0: return IN_W'({$urandom, $urandom});
			1: begin
				if (act == ACT_CONVERT) return md_stamp($urandom_range(0, 1899), 6, 1, h, m);
				return doy_stamp($urandom_range(0, 1899), 100, h, m);
			end
			2: begin
				if (act == ACT_CONVERT)
					return md_stamp(y, $urandom_range(0, 99), $urandom_range(0, 99), h, m);
				return doy_stamp(y, $urandom_range(0, 999), h, m);
			end
			default: begin
				if (act == ACT_CONVERT) begin
					mo = $urandom_range(1, 12);
					d = $urandom_range(0, 2) == 0 ? int'(days_in_month(lp, mo))
						: $urandom_range(1, int'(days_in_month(lp, mo)));
					return md_stamp(y, mo, d, h, m);
				end
				d = $urandom_range(0, 2) == 0 ? 365 + lp - $urandom_range(0, 1)
					: $urandom_range(1, 365 + lp);
				return doy_stamp(y, d, h, m);
			end
		endcase
	endfunction

	initial begin
		logic act;
		logic [HOUR_BITS-1:0] hrs;
		int burst;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send(ACT_CONVERT, md_stamp(1900, 1, 1, 0, 0), 16'hFFFF);
		send(ACT_CONVERT, md_stamp(9999, 12, 31, 23, 59), '0);
		send(ACT_CONVERT, md_stamp(2000, 2, 29, 12, 30), '0);
		send(ACT_CONVERT, md_stamp(1900, 2, 29, 0, 0), '0);
		send(ACT_CONVERT, md_stamp(2024, 12, 31, 0, 0), '0);
		send(ACT_CONVERT, md_stamp(1899, 12, 31, 23, 59), '0);
		send(ACT_CONVERT, md_stamp(2023, 13, 1, 0, 0), '0);
		send(ACT_CONVERT, md_stamp(2023, 0, 1, 0, 0), '0);
		send(ACT_CONVERT, md_stamp(2023, 4, 31, 0, 0), '0);
		send(ACT_CONVERT, md_stamp(2023, 5, 1, 24, 0), '0);
		send(ACT_CONVERT, md_stamp(2023, 5, 1, 0, 60), '0);
		send(ACT_CONVERT, '1, '0);
		send(ACT_CONVERT, '0, '0);
		send(ACT_ADD_HOURS, doy_stamp(2023, 100, 10, 15), '0);
		send(ACT_ADD_HOURS, doy_stamp(1900, 1, 0, 0), 16'hFFFF);
		send(ACT_ADD_HOURS, doy_stamp(2000, 366, 23, 59), 16'd1);
		send(ACT_ADD_HOURS, doy_stamp(2001, 366, 0, 0), 16'd1);
		send(ACT_ADD_HOURS, doy_stamp(9999, 365, 23, 0), 16'd1);
		send(ACT_ADD_HOURS, doy_stamp(9999, 365, 22, 59), 16'd1);
		send(ACT_ADD_HOURS, doy_stamp(9992, 1, 0, 0), 16'hFFFF);
		send(ACT_ADD_HOURS, doy_stamp(2023, 0, 0, 0), 16'd5);
		send(ACT_ADD_HOURS, doy_stamp(2023, 10, 24, 0), 16'd5);
		send(ACT_ADD_HOURS, doy_stamp(1899, 365, 0, 0), 16'd5);
		send(ACT_ADD_HOURS, '1, 16'hFFFF);
		start <= 1'b0;
		@(posedge clk);

		// random bursts
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
				act = 1'($urandom);
				case ($urandom_range(0, 3))
					0: hrs = HOUR_BITS'($urandom_range(0, 47));
					1: hrs = HOUR_BITS'($urandom_range(8000, 65535));
					default: hrs = HOUR_BITS'($urandom);
				endcase
				send(act, rand_stamp(act), hrs);
			end
			pause($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40));
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
